@@ rtl/core/first_match_prefix_router_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the prefix router
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FIRST_MATCH_PREFIX_ROUTER_UNIT_MACROS_SVH
`define FIRST_MATCH_PREFIX_ROUTER_UNIT_MACROS_SVH

// same-cycle implication
`define FMPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prefix router: implication check failed");

// next-cycle implication
`define FMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prefix router: next-cycle check failed");

`endif

@@ rtl/core/fmpr_pkg.sv @@
// ---------------------------------------------------------------------------
// fmpr_pkg
// Command codes, stream field layout and shared types of the prefix router.
// ---------------------------------------------------------------------------
package fmpr_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned METH_W  = 8;
  localparam int unsigned ELEN_W  = 7;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 7;

  localparam logic [CMD_W-1:0] CMD_WR_HDR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_BYTE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PATH_BYTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PATH_END  = 2'd3;

  // in_tdata layout
  localparam int unsigned IN_IDX_LSB  = 0;
  localparam int unsigned IN_METH_LSB = IN_IDX_LSB + IDX_W;
  localparam int unsigned IN_ELEN_LSB = IN_METH_LSB + METH_W;
  localparam int unsigned IN_OFF_LSB  = IN_ELEN_LSB + ELEN_W;
  localparam int unsigned IN_DATA_LSB = IN_OFF_LSB + OFF_W;
  localparam int unsigned IN_RMTH_LSB = IN_DATA_LSB + BYTE_W;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  typedef struct packed {
    logic             hdr_we;
    logic             cmp_en;
    logic             rearm;
    logic [IDX_W-1:0] idx;
  } lane_cmd_t;

endpackage

@@ rtl/core/fmpr_byte_mem.sv @@
// ---------------------------------------------------------------------------
// fmpr_byte_mem
// Prefix byte store, one row per prefix position, one byte lane per route.
// ---------------------------------------------------------------------------
module fmpr_byte_mem #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned MAX_PREFIX = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1)-1:0] waddr,
  input  logic [((MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1)-1:0] wlane,
  input  logic [fmpr_pkg::BYTE_W-1:0]               wdata,
  input  logic                                      re,
  input  logic [((MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1)-1:0] raddr,
  output logic [MAX_ROUTES*fmpr_pkg::BYTE_W-1:0]    rdata
);

  localparam int unsigned ROW_W = MAX_ROUTES * fmpr_pkg::BYTE_W;

  logic [ROW_W-1:0] mem [MAX_PREFIX];
  logic [ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][{wlane, 3'b000} +: fmpr_pkg::BYTE_W] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fmpr_hdr_mem.sv @@
// ---------------------------------------------------------------------------
// fmpr_hdr_mem
// Route header store: method code and prefix length per route.
// ---------------------------------------------------------------------------
module fmpr_hdr_mem #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned HDR_W      = 15
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1)-1:0] waddr,
  input  logic [HDR_W-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1)-1:0] raddr,
  output logic [HDR_W-1:0]                          rdata
);

  logic [HDR_W-1:0] mem [MAX_ROUTES];
  logic [HDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fmpr_lanes.sv @@
// ---------------------------------------------------------------------------
// fmpr_lanes
// Per-route compare lanes: prefix length copy and live flag of each route.
// ---------------------------------------------------------------------------
module fmpr_lanes #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned MAX_PREFIX = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fmpr_pkg::lane_cmd_t                    cmd,
  input  logic [$clog2(MAX_PREFIX+1)-1:0]        len,
  input  logic [$clog2(MAX_PREFIX+1)-1:0]        pos,
  input  logic [fmpr_pkg::BYTE_W-1:0]            path_byte,
  input  logic [MAX_ROUTES*fmpr_pkg::BYTE_W-1:0] row,
  output logic [MAX_ROUTES-1:0]                  live
);

  localparam int unsigned LW = $clog2(MAX_PREFIX + 1);
  localparam int unsigned RW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

  logic [LW-1:0]         len_r [MAX_ROUTES];
  logic [MAX_ROUTES-1:0] live_r;
  logic [MAX_ROUTES-1:0] miss;

  always_ff @(posedge clk) begin
    if (cmd.hdr_we) begin
      len_r[RW'(cmd.idx)] <= len;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ROUTES; i++) begin
      miss[i] = (pos < len_r[i]) &&
                (row[i*fmpr_pkg::BYTE_W +: fmpr_pkg::BYTE_W] != path_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '1;
    end else if (cmd.rearm) begin
      live_r <= '1;
    end else if (cmd.cmp_en) begin
      live_r <= live_r & ~miss;
    end
  end

  assign live = live_r;

endmodule

@@ rtl/core/first_match_prefix_router_unit.sv @@
// ---------------------------------------------------------------------------
// first_match_prefix_router_unit
// First-match route lookup over byte-prefix routes with method filter.
// ---------------------------------------------------------------------------
//  channel | ports                          | carries
//  in      | in_tvalid/in_tready/in_tdata   | table writes, path bytes, path end
//          | in_tuser                       | command
//  out     | out_tvalid/out_tready/out_tdata| matched route, found in out_tuser
//  cfg     | cfg_valid/cfg_ready/cfg_data   | active_routes
//
//  Header and byte writes leave the block idle; a path byte reads its row of
//  the byte memory, then all lanes compare at once, unless the position has
//  saturated. Path end scans the header memory one route a cycle, over
//  min(active_routes, MAX_ROUTES) routes, stopping at the first hit.
//  One request is in work at a time; a finished result waits in the output
//  register while the next request is taken. Reset is synchronous: live
//  flags set, path position and output cleared, no clearing pass.
// ---------------------------------------------------------------------------
module first_match_prefix_router_unit #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned MAX_PREFIX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // entry_index, entry_method, entry_length, byte_offset, data_byte,
  // request_method, zero pad
  input  logic [fmpr_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command
  input  logic [fmpr_pkg::CMD_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // matched_route, zero pad
  output logic [fmpr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // found
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fmpr_pkg::CFG_W-1:0]           cfg_data
);

  localparam int unsigned RW    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int unsigned PW    = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
  localparam int unsigned LW    = $clog2(MAX_PREFIX + 1);
  localparam int unsigned CW    = $clog2(MAX_ROUTES + 1);
  localparam int unsigned HDR_W = fmpr_pkg::METH_W + LW;

  logic [fmpr_pkg::IDX_W-1:0]  in_idx;
  logic [fmpr_pkg::METH_W-1:0] in_meth;
  logic [fmpr_pkg::ELEN_W-1:0] in_len;
  logic [fmpr_pkg::OFF_W-1:0]  in_off;
  logic [fmpr_pkg::BYTE_W-1:0] in_data;
  logic [fmpr_pkg::METH_W-1:0] in_rmeth;

  assign in_idx   = in_tdata[fmpr_pkg::IN_IDX_LSB  +: fmpr_pkg::IDX_W];
  assign in_meth  = in_tdata[fmpr_pkg::IN_METH_LSB +: fmpr_pkg::METH_W];
  assign in_len   = in_tdata[fmpr_pkg::IN_ELEN_LSB +: fmpr_pkg::ELEN_W];
  assign in_off   = in_tdata[fmpr_pkg::IN_OFF_LSB  +: fmpr_pkg::OFF_W];
  assign in_data  = in_tdata[fmpr_pkg::IN_DATA_LSB +: fmpr_pkg::BYTE_W];
  assign in_rmeth = in_tdata[fmpr_pkg::IN_RMTH_LSB +: fmpr_pkg::METH_W];

  fmpr_pkg::state_t state_r, state_nxt;

  logic [fmpr_pkg::CFG_W-1:0]  cfg_active_r;
  logic [LW-1:0]               pos_r;
  logic [fmpr_pkg::BYTE_W-1:0] byte_r;
  logic [fmpr_pkg::METH_W-1:0] rmeth_r;
  logic [CW-1:0]               issue_r;
  logic                        rd_vld_r;
  logic [RW-1:0]               rd_idx_r;
  logic                        res_found_r;
  logic [RW-1:0]               res_idx_r;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [fmpr_pkg::IDX_W-1:0]  out_idx_r;

  logic                        acc;
  logic                        idx_ok;
  logic                        off_ok;
  logic                        pos_lt;
  logic [LW-1:0]               len_sat;
  logic [CW-1:0]               scan_cnt;
  logic                        issue_en;
  logic                        hit;
  logic                        scan_done;
  logic                        out_free;
  logic                        load_scan;
  logic                        load_hold;
  fmpr_pkg::lane_cmd_t         lane_cmd;
  logic [MAX_ROUTES-1:0]       live_vec;
  logic [MAX_ROUTES*fmpr_pkg::BYTE_W-1:0] row_data;
  logic [HDR_W-1:0]            hdr_rdata;
  logic [fmpr_pkg::METH_W-1:0] hdr_meth;
  logic [LW-1:0]               hdr_len;
  logic                        byte_we;
  logic                        byte_re;

  assign in_tready = (state_r == fmpr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;

  assign idx_ok  = 32'(in_idx) < 32'(MAX_ROUTES);
  assign off_ok  = 32'(in_off) < 32'(MAX_PREFIX);
  assign pos_lt  = 32'(pos_r) < 32'(MAX_PREFIX);
  assign len_sat = (32'(in_len) > 32'(MAX_PREFIX)) ? LW'(MAX_PREFIX) : LW'(in_len);
  assign scan_cnt = (32'(cfg_active_r) > 32'(MAX_ROUTES)) ? CW'(MAX_ROUTES)
                                                           : CW'(cfg_active_r);

  assign hdr_meth = hdr_rdata[LW +: fmpr_pkg::METH_W];
  assign hdr_len  = hdr_rdata[LW-1:0];

  assign issue_en  = (state_r == fmpr_pkg::ST_SCAN) && (issue_r < scan_cnt);
  assign hit       = rd_vld_r && live_vec[rd_idx_r] &&
                     ((hdr_meth == '0) || (hdr_meth == rmeth_r)) &&
                     (hdr_len <= pos_r);
  assign scan_done = (state_r == fmpr_pkg::ST_SCAN) && (hit || (!rd_vld_r && !issue_en));
  assign out_free  = !out_valid_r || out_tready;
  assign load_scan = scan_done && out_free;
  assign load_hold = (state_r == fmpr_pkg::ST_HOLD) && out_free;

  assign byte_we = acc && (in_tuser == fmpr_pkg::CMD_WR_BYTE) && idx_ok && off_ok;
  assign byte_re = acc && (in_tuser == fmpr_pkg::CMD_PATH_BYTE) && pos_lt;

  always_comb begin
    lane_cmd.hdr_we = acc && (in_tuser == fmpr_pkg::CMD_WR_HDR) && idx_ok;
    lane_cmd.cmp_en = (state_r == fmpr_pkg::ST_CMP);
    lane_cmd.rearm  = scan_done;
    lane_cmd.idx    = in_idx;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fmpr_pkg::ST_IDLE: begin
        if (byte_re) begin
          state_nxt = fmpr_pkg::ST_CMP;
        end else if (acc && (in_tuser == fmpr_pkg::CMD_PATH_END)) begin
          state_nxt = fmpr_pkg::ST_SCAN;
        end
      end
      fmpr_pkg::ST_CMP: begin
        state_nxt = fmpr_pkg::ST_IDLE;
      end
      fmpr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = out_free ? fmpr_pkg::ST_IDLE : fmpr_pkg::ST_HOLD;
        end
      end
      fmpr_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = fmpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fmpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fmpr_pkg::ST_IDLE;
      cfg_active_r <= '0;
      pos_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_active_r <= cfg_data;
      end
      if (scan_done) begin
        pos_r <= '0;
      end else if (state_r == fmpr_pkg::ST_CMP) begin
        pos_r <= pos_r + 1'b1;
      end
      rd_vld_r <= issue_en;
      if (load_scan || load_hold) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r  <= in_data;
      rmeth_r <= in_rmeth;
    end
    if (acc && (in_tuser == fmpr_pkg::CMD_PATH_END)) begin
      issue_r <= '0;
    end else if (issue_en) begin
      issue_r <= issue_r + 1'b1;
    end
    rd_idx_r <= RW'(issue_r);
    if (scan_done) begin
      res_found_r <= hit;
      res_idx_r   <= hit ? rd_idx_r : '0;
    end
    if (load_scan) begin
      out_found_r <= hit;
      out_idx_r   <= hit ? fmpr_pkg::IDX_W'(rd_idx_r) : '0;
    end else if (load_hold) begin
      out_found_r <= res_found_r;
      out_idx_r   <= fmpr_pkg::IDX_W'(res_idx_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = fmpr_pkg::OUT_TDATA_W'(out_idx_r);

  fmpr_byte_mem #(
    .MAX_ROUTES (MAX_ROUTES),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_byte_mem (
    .clk   (clk),
    .we    (byte_we),
    .waddr (PW'(in_off)),
    .wlane (RW'(in_idx)),
    .wdata (in_data),
    .re    (byte_re),
    .raddr (PW'(pos_r)),
    .rdata (row_data)
  );

  fmpr_hdr_mem #(
    .MAX_ROUTES (MAX_ROUTES),
    .HDR_W      (HDR_W)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (lane_cmd.hdr_we),
    .waddr (RW'(in_idx)),
    .wdata ({in_meth, len_sat}),
    .re    (issue_en),
    .raddr (RW'(issue_r)),
    .rdata (hdr_rdata)
  );

  fmpr_lanes #(
    .MAX_ROUTES (MAX_ROUTES),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (lane_cmd),
    .len       (len_sat),
    .pos       (pos_r),
    .path_byte (byte_r),
    .row       (row_data),
    .live      (live_vec)
  );

endmodule

@@ rtl/core/fmpr_checker.sv @@
// ---------------------------------------------------------------------------
// fmpr_checker
// Port-level checks of the prefix router, bound to the top level.
// ---------------------------------------------------------------------------
`include "first_match_prefix_router_unit_macros.svh"

module fmpr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [fmpr_pkg::CMD_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fmpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  logic in_acc;
  logic tbl_wr;
  logic path_end;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready;
  assign tbl_wr    = in_acc && ((in_tuser == fmpr_pkg::CMD_WR_HDR) ||
                                (in_tuser == fmpr_pkg::CMD_WR_BYTE));
  assign path_end  = in_acc && (in_tuser == fmpr_pkg::CMD_PATH_END);
  assign out_stall = out_tvalid && !out_tready;

  // stalled result holds
  `FMPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tdata, out_tuser}))

  // a miss reports route zero
  `FMPR_ASSERT_IMP(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0)

  // table writes leave the input ready
  `FMPR_ASSERT_NEXT(a_wr_single, clk, rst_n, tbl_wr, in_tready)

  // path end starts the route scan
  `FMPR_ASSERT_NEXT(a_end_busy, clk, rst_n, path_end, !in_tready)

endmodule

bind first_match_prefix_router_unit fmpr_checker u_fmpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/tb_first_match_prefix_router_unit.sv @@
// ---------------------------------------------------------------------------
// tb_first_match_prefix_router_unit
// Self-checking bench for the prefix router. A queue-fed driver sends route
// table writes, path bytes and path ends; the monitor predicts every lookup
// and checks each returned route against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_first_match_prefix_router_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fmpr_pkg::*;

  localparam int ROUTES         = 64;
  localparam int PREFIX         = 64;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [METH_W-1:0] meth;
    logic [ELEN_W-1:0] elen;
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] data;
    logic [METH_W-1:0] rmeth;
  } route_req_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] route;
  } lookup_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;

  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  route_req_t     request_q[$];
  lookup_result_t expected_routes[$];
  int pushed_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // lookup state as the block should hold it
  logic [METH_W-1:0] pred_meth[ROUTES];
  int                pred_len[ROUTES];
  logic [BYTE_W-1:0] pred_bytes[ROUTES][PREFIX];
  logic [ROUTES-1:0] pred_live = '1;
  int                pred_pos  = 0;
  int                pred_active = 0;

  // table contents as the stimulus has written them
  logic [METH_W-1:0] map_meth[ROUTES];
  int                map_len[ROUTES];
  logic [BYTE_W-1:0] map_bytes[ROUTES][PREFIX];
  int                gen_active = 0;

  first_match_prefix_router_unit #(
    .MAX_ROUTES(ROUTES),
    .MAX_PREFIX(PREFIX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(input route_req_t r);
    logic [IN_TDATA_W-1:0] v;
    v = '0;
    v[IN_IDX_LSB  +: IDX_W]  = r.idx;
    v[IN_METH_LSB +: METH_W] = r.meth;
    v[IN_ELEN_LSB +: ELEN_W] = r.elen;
    v[IN_OFF_LSB  +: OFF_W]  = r.off;
    v[IN_DATA_LSB +: BYTE_W] = r.data;
    v[IN_RMTH_LSB +: METH_W] = r.rmeth;
    return v;
  endfunction

  function automatic route_req_t unpack_request(input logic [IN_TDATA_W-1:0] v,
                                                input logic [CMD_W-1:0] cmd);
    route_req_t r;
    r.cmd   = cmd;
    r.idx   = v[IN_IDX_LSB  +: IDX_W];
    r.meth  = v[IN_METH_LSB +: METH_W];
    r.elen  = v[IN_ELEN_LSB +: ELEN_W];
    r.off   = v[IN_OFF_LSB  +: OFF_W];
    r.data  = v[IN_DATA_LSB +: BYTE_W];
    r.rmeth = v[IN_RMTH_LSB +: METH_W];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic route_lookup_predict(input route_req_t r);
    int i;
    int n;
    bit hit;
    int which;
    lookup_result_t res;
    case (r.cmd)
      CMD_WR_HDR: begin
        pred_meth[r.idx] = r.meth;
        pred_len[r.idx]  = (r.elen > PREFIX) ? PREFIX : int'(r.elen);
      end
      CMD_WR_BYTE: pred_bytes[r.idx][r.off] = r.data;
      CMD_PATH_BYTE: begin
        if (pred_pos < PREFIX) begin
          for (i = 0; i < ROUTES; i++)
            if (pred_pos < pred_len[i] && pred_bytes[i][pred_pos] != r.data)
              pred_live[i] = 1'b0;
          pred_pos++;
        end
      end
      CMD_PATH_END: begin
        n = (pred_active > ROUTES) ? ROUTES : pred_active;
        hit = 1'b0;
        which = 0;
        for (i = 0; i < n; i++)
          if (!hit && pred_live[i] && (pred_meth[i] == '0 || pred_meth[i] == r.rmeth) &&
              pred_len[i] <= pred_pos) begin
            hit = 1'b1;
            which = i;
          end
        res.found = hit;
        res.route = hit ? which[IDX_W-1:0] : '0;
        expected_routes.push_back(res);
        pred_live = '1;
        pred_pos  = 0;
      end
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pack_request(request_q[0]);
        in_tuser  <= request_q[0].cmd;
        void'(request_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin : monitor
    lookup_result_t exp_res;
    in_taken  <= rst_n && in_tvalid && in_tready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pred_active = int'(cfg_data);
      if (out_tvalid && out_tready) begin
        if (expected_routes.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0d route=%0d",
                                    out_tuser, out_tdata[IDX_W-1:0]));
        end else begin
          exp_res = expected_routes.pop_front();
          if (out_tuser !== exp_res.found)
            report_mismatch($sformatf("found: got %0d expected %0d",
                                      out_tuser, exp_res.found));
          if (out_tdata[IDX_W-1:0] !== exp_res.route)
            report_mismatch($sformatf("matched_route: got %0d expected %0d",
                                      out_tdata[IDX_W-1:0], exp_res.route));
        end
      end
      if (in_tvalid && in_tready) begin
        route_lookup_predict(unpack_request(in_tdata, in_tuser));
        accepted_count++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_first_match_prefix_router_unit NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic route_req_t rand_req(input logic [CMD_W-1:0] cmd);
    route_req_t r;
    r.cmd   = cmd;
    r.idx   = IDX_W'($urandom);
    r.meth  = METH_W'($urandom);
    r.elen  = ELEN_W'($urandom);
    r.off   = OFF_W'($urandom);
    r.data  = BYTE_W'($urandom);
    r.rmeth = METH_W'($urandom);
    return r;
  endfunction

  function automatic logic [METH_W-1:0] rand_method();
    int p;
    p = $urandom_range(99);
    if (p < 20) return '0;
    if (p < 80) return METH_W'($urandom_range(3, 1));
    return METH_W'($urandom_range(255));
  endfunction

  function automatic int rand_len();
    int p;
    p = $urandom_range(99);
    if (p < 8)  return 0;
    if (p < 85) return $urandom_range(8, 1);
    if (p < 95) return $urandom_range(63, 9);
    if (p < 98) return PREFIX;
    return $urandom_range(127, PREFIX + 1);
  endfunction

  task automatic push_request(input route_req_t r);
    request_q.push_back(r);
    pushed_count++;
  endtask

  task automatic put_header(input int idx, input logic [METH_W-1:0] meth, input int elen);
    route_req_t r;
    r = rand_req(CMD_WR_HDR);
    r.idx  = IDX_W'(idx);
    r.meth = meth;
    r.elen = ELEN_W'(elen);
    push_request(r);
    map_meth[idx] = meth;
    map_len[idx]  = (elen > PREFIX) ? PREFIX : elen;
  endtask

  task automatic put_byte(input int idx, input int off, input logic [BYTE_W-1:0] b);
    route_req_t r;
    r = rand_req(CMD_WR_BYTE);
    r.idx  = IDX_W'(idx);
    r.off  = OFF_W'(off);
    r.data = b;
    push_request(r);
    map_bytes[idx][off] = b;
  endtask

  task automatic put_path_byte(input logic [BYTE_W-1:0] b);
    route_req_t r;
    r = rand_req(CMD_PATH_BYTE);
    r.data = b;
    push_request(r);
  endtask

  task automatic put_path_end(input logic [METH_W-1:0] m);
    route_req_t r;
    r = rand_req(CMD_PATH_END);
    r.rmeth = m;
    push_request(r);
  endtask

  // prefix bytes first, header last, so no compare ever sees an unwritten byte
  task automatic put_route(input int idx, input logic [METH_W-1:0] meth, input int elen,
                           input int copy_from);
    int n;
    int k;
    logic [BYTE_W-1:0] b;
    n = (elen > PREFIX) ? PREFIX : elen;
    for (k = 0; k < n; k++) begin
      b = BYTE_W'($urandom);
      if (copy_from >= 0 && k < map_len[copy_from]) b = map_bytes[copy_from][k];
      put_byte(idx, k, b);
    end
    put_header(idx, meth, elen);
  endtask

  task automatic put_random_route();
    int idx;
    idx = $urandom_range(ROUTES - 1);
    put_route(idx, rand_method(), rand_len(),
              ($urandom_range(99) < 30) ? int'($urandom_range(ROUTES - 1)) : -1);
  endtask

  task automatic put_lookup();
    int lim;
    int t;
    int plen;
    int flip_at;
    int upd_at;
    int n;
    int k;
    bit long_path;
    logic [BYTE_W-1:0] b;
    logic [METH_W-1:0] m;
    lim = (gen_active > ROUTES) ? ROUTES : gen_active;
    if (lim > 0 && $urandom_range(99) < 75) t = $urandom_range(lim - 1);
    else t = $urandom_range(ROUTES - 1);
    long_path = ($urandom_range(99) < 4);
    if (long_path && $urandom_range(1)) t = ROUTES - 1;
    plen = map_len[t];
    flip_at = ($urandom_range(99) < 12 && plen > 0) ? int'($urandom_range(plen - 1)) : -1;
    upd_at  = ($urandom_range(99) < 6) ? int'($urandom_range(plen)) : -1;
    n = long_path ? PREFIX + int'($urandom_range(8, 1)) : plen + int'($urandom_range(3));
    for (k = 0; k < n; k++) begin
      if (k == upd_at) put_random_route();
      b = BYTE_W'($urandom);
      if (k < map_len[t]) b = map_bytes[t][k];
      if (k == flip_at) b = b ^ (8'h01 << $urandom_range(7));
      put_path_byte(b);
    end
    m = (map_meth[t] != '0) ? map_meth[t] : METH_W'($urandom);
    if ($urandom_range(99) < 10) m = METH_W'($urandom);
    put_path_end(m);
  endtask

  task automatic put_noise();
    int n;
    int k;
    n = $urandom_range(6);
    for (k = 0; k < n; k++) put_path_byte(BYTE_W'($urandom));
    put_path_end(METH_W'($urandom));
  endtask

  task automatic random_traffic(input int n);
    int start;
    int p;
    start = pushed_count;
    while (pushed_count - start < n) begin
      p = $urandom_range(99);
      if (p < 10)      put_random_route();
      else if (p < 90) put_lookup();
      else             put_noise();
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (accepted_count != pushed_count || expected_routes.size() != 0);
  endtask

  task automatic write_active_routes(input int value);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    gen_active = value;
  endtask

  initial begin
    int r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_active_routes(ROUTES);
    for (r = 0; r < ROUTES; r++) begin
      if (r == ROUTES - 1)      put_route(r, 8'h80, 127, -1);
      else if (r == ROUTES - 2) put_route(r, rand_method(), PREFIX, -1);
      else put_route(r, rand_method(), rand_len(),
                     (r > 0 && $urandom_range(99) < 30) ? int'($urandom_range(r - 1)) : -1);
    end

    // empty path against a zero-length route
    put_header(0, 8'hFF, 0);
    put_path_end(8'hFF);
    put_path_end(8'h00);
    // any-method route
    put_byte(1, 0, 8'h00);
    put_byte(1, 1, 8'hFF);
    put_header(1, 8'h00, 2);
    put_path_byte(8'h00);
    put_path_byte(8'hFF);
    put_path_end(8'h5A);
    // byte rewritten ahead of the path position
    put_path_byte(8'h00);
    put_byte(1, 1, 8'h11);
    put_path_byte(8'h11);
    put_path_end(8'h01);
    // byte rewritten behind the path position keeps the old compare
    put_path_byte(8'h22);
    put_byte(1, 0, 8'h22);
    put_path_byte(8'h11);
    put_path_end(8'h01);
    put_path_byte(8'h22);
    put_path_byte(8'h11);
    put_path_end(8'hA5);
    random_traffic(200);

    write_active_routes(127);
    send_idle_pct = 68;
    recv_stall_pct = 0;
    random_traffic(250);

    write_active_routes(0);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    random_traffic(100);

    write_active_routes($urandom_range(63, 1));
    send_idle_pct = 16;
    recv_stall_pct = 16;
    random_traffic(250);

    write_active_routes(ROUTES);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_traffic(100);
    wait_quiet();
    random_traffic(100);

    write_active_routes($urandom_range(126, ROUTES + 1));
    send_idle_pct = 16;
    recv_stall_pct = 16;
    random_traffic(200);

    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_first_match_prefix_router_unit OK");
    end else begin
      $display("tb_first_match_prefix_router_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fmpr_pkg.sv
rtl/core/fmpr_byte_mem.sv
rtl/core/fmpr_hdr_mem.sv
rtl/core/fmpr_lanes.sv
rtl/core/first_match_prefix_router_unit.sv
rtl/core/fmpr_checker.sv
verif/tb_first_match_prefix_router_unit.sv
